@@ rtl/smas_pkg.sv @@
// Shared types and constants for the square matrix add/subtract/multiply core.
package smas_pkg;

	localparam int ELEM_W = 16;
	localparam int IDX_W  = 4;
	localparam int SIZE_W = 5;
	localparam int OP_W   = 2;
	localparam int SUM_W  = 17;
	localparam int MUL_W  = 32;
	localparam int PROD_W = 36;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE_A = 2'd0,
		OP_WRITE_B = 2'd1,
		OP_QUERY   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Sequencer to datapath controls
	typedef struct packed {
		logic clear;
		logic rd;
		logic cap_a;
		logic cap_b;
	} mac_ctl_t;

endpackage

@@ rtl/smas_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module smas_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/smas_mac.sv @@
// Datapath: multiply-accumulate pipeline and element sum/difference capture.
module smas_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  smas_pkg::mac_ctl_t                   ctl,
	input  logic [smas_pkg::ELEM_W-1:0]          rdata_a,
	input  logic [smas_pkg::ELEM_W-1:0]          rdata_b,
	output logic signed [smas_pkg::SUM_W-1:0]    sum,
	output logic signed [smas_pkg::SUM_W-1:0]    difference,
	output logic signed [smas_pkg::PROD_W-1:0]   product,
	output logic                                 busy
);
	import smas_pkg::*;

	logic                     vld_s1;
	logic                     cap_a_s1;
	logic                     cap_b_s1;
	logic                     vld_s2;
	logic signed [MUL_W-1:0]  prod_s2;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [ELEM_W-1:0] a_q;
	logic signed [ELEM_W-1:0] b_q;

	// Request flags are registered so they line up with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			cap_a_s1 <= 1'b0;
			cap_b_s1 <= 1'b0;
			vld_s2   <= 1'b0;
		end else begin
			vld_s1   <= ctl.rd;
			cap_a_s1 <= ctl.cap_a;
			cap_b_s1 <= ctl.cap_b;
			vld_s2   <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			prod_s2 <= $signed(rdata_a) * $signed(rdata_b);
		end
		// A[row][col] passes by at k == col, B[row][col] at k == row
		if (cap_a_s1) begin
			a_q <= $signed(rdata_a);
		end
		if (cap_b_s1) begin
			b_q <= $signed(rdata_b);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + PROD_W'(prod_s2);
		end
	end

	assign sum        = SUM_W'(a_q) + SUM_W'(b_q);
	assign difference = SUM_W'(a_q) - SUM_W'(b_q);
	assign product    = acc_q;
	assign busy       = vld_s1 | vld_s2;

endmodule

@@ rtl/smas_ctrl.sv @@
// Sequencer: request decode, memory addressing and the row-by-column walk.
module smas_ctrl #(
	parameter int MAX_N = 16,
	localparam int AW = $clog2(MAX_N * MAX_N)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [smas_pkg::OP_W-1:0]     in_op,
	input  logic [smas_pkg::IDX_W-1:0]    in_row,
	input  logic [smas_pkg::IDX_W-1:0]    in_col,
	input  logic [smas_pkg::SIZE_W-1:0]   size,
	input  logic                          mac_busy,
	input  logic                          out_free,
	output logic                          we_a,
	output logic                          we_b,
	output logic [AW-1:0]                 waddr,
	output logic [AW-1:0]                 raddr_a,
	output logic [AW-1:0]                 raddr_b,
	output smas_pkg::mac_ctl_t            ctl,
	output logic                          load_out,
	output logic                          bad
);
	import smas_pkg::*;

	localparam int KW = $clog2(MAX_N);

	state_t            state_q;
	state_t            state_d;
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic [KW-1:0]     k_q;
	logic              bad_q;
	logic              in_accept;
	logic              in_range;
	logic              is_query;
	logic              k_last;

	assign in_accept = in_valid && in_ready;
	assign is_query  = (in_op == OP_QUERY);
	// Active size is the smaller of the register and MAX_N
	assign in_range  = ({1'b0, in_row} < size) && (32'(in_row) < MAX_N)
		&& ({1'b0, in_col} < size) && (32'(in_col) < MAX_N);
	assign k_last    = (32'(k_q) + 1 == 32'(size)) || (32'(k_q) + 1 == MAX_N);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && is_query) begin
					state_d = in_range ? ST_RUN : ST_DONE;
				end
			end
			ST_RUN: begin
				if (k_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!mac_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && is_query) begin
			row_q <= in_row;
			col_q <= in_col;
			k_q   <= '0;
			bad_q <= !in_range;
		end else if (state_q == ST_RUN) begin
			k_q <= k_q + 1'b1;
		end
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		we_a      = in_accept && (in_op == OP_WRITE_A) && in_range;
		we_b      = in_accept && (in_op == OP_WRITE_B) && in_range;
		waddr     = AW'(32'(in_row) * MAX_N + 32'(in_col));
		raddr_a   = AW'(32'(row_q) * MAX_N + 32'(k_q));
		raddr_b   = AW'(32'(k_q) * MAX_N + 32'(col_q));
		ctl.clear = in_accept && is_query;
		ctl.rd    = (state_q == ST_RUN);
		ctl.cap_a = ctl.rd && (32'(k_q) == 32'(col_q));
		ctl.cap_b = ctl.rd && (32'(k_q) == 32'(row_q));
		load_out  = (state_q == ST_DONE) && out_free;
		bad       = bad_q;
	end

endmodule

@@ rtl/square_matrix_add_sub_mul_core.sv @@
// Top level of the square matrix add/subtract/multiply core.
// Holds matrices A and B (signed Q8.8, MAX_N x MAX_N each) in two RAMs and
// answers a query for (row, col) with A+B, A-B and the Q20.16 dot product of
// row "row" of A with column "col" of B over the active size n, which is the
// smaller of matrix_size and MAX_N. A query inside the matrix walks k over
// the active size: each matrix RAM has one read port, so the walk does one
// multiply-accumulate per cycle, followed by the read and multiply pipeline
// drain and the result handoff to the output register. A query outside the
// matrix skips the walk and returns zeros with bad_index set. Requests are
// taken while an earlier result still waits in the output register, until
// the next result needs that register.
module square_matrix_add_sub_mul_core #(
	parameter int MAX_N = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data,    // matrix_size
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // row[3:0], col[7:4], value[23:8]
	input  logic [1:0]  s_axis_tuser,   // operation[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // sum[16:0], difference[33:17], product[69:34], zero pad
	output logic [0:0]  m_axis_tuser    // bad_index[0]
);
	import smas_pkg::*;

	localparam int DEPTH = MAX_N * MAX_N;
	localparam int AW    = $clog2(DEPTH);

	logic [SIZE_W-1:0]        size_q;
	logic                     we_a;
	logic                     we_b;
	logic [AW-1:0]            waddr;
	logic [AW-1:0]            raddr_a;
	logic [AW-1:0]            raddr_b;
	logic [ELEM_W-1:0]        rdata_a;
	logic [ELEM_W-1:0]        rdata_b;
	mac_ctl_t                 ctl;
	logic                     mac_busy;
	logic                     out_free;
	logic                     load_out;
	logic                     bad;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  difference;
	logic signed [PROD_W-1:0] product;
	logic                     out_valid_q;
	logic [SUM_W-1:0]         sum_q;
	logic [SUM_W-1:0]         diff_q;
	logic [PROD_W-1:0]        prod_q;
	logic                     bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_wr_en) begin
			size_q <= cfg_wr_data;
		end
	end

	smas_ctrl #(
		.MAX_N(MAX_N)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_op    (s_axis_tuser),
		.in_row   (s_axis_tdata[3:0]),
		.in_col   (s_axis_tdata[7:4]),
		.size     (size_q),
		.mac_busy (mac_busy),
		.out_free (out_free),
		.we_a     (we_a),
		.we_b     (we_b),
		.waddr    (waddr),
		.raddr_a  (raddr_a),
		.raddr_b  (raddr_b),
		.ctl      (ctl),
		.load_out (load_out),
		.bad      (bad)
	);

	smas_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(DEPTH)
	) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (s_axis_tdata[23:8]),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	smas_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(DEPTH)
	) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (s_axis_tdata[23:8]),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	smas_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.rdata_a    (rdata_a),
		.rdata_b    (rdata_b),
		.sum        (sum),
		.difference (difference),
		.product    (product),
		.busy       (mac_busy)
	);

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Out-of-range queries report zeros
	always_ff @(posedge clk) begin
		if (load_out) begin
			sum_q  <= bad ? '0 : sum;
			diff_q <= bad ? '0 : difference;
			prod_q <= bad ? '0 : product;
			bad_q  <= bad;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, prod_q, diff_q, sum_q};
	assign m_axis_tuser  = bad_q;

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("bad_index result with nonzero payload");

	a_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !mac_busy)
		else $error("request taken while multiply pipeline busy");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> m_axis_tvalid)
		else $error("result lost on handoff to output register");

	a_no_walk_write: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd |-> !we_a && !we_b)
		else $error("matrix write during row-by-column walk");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the square matrix add/subtract/multiply core.
module tb_top;
	import smas_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int DIM          = 16;
	localparam int SETTLE       = 32;
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASE_ITEMS  = 190;

	typedef struct {
		logic [SUM_W-1:0]  sum;
		logic [SUM_W-1:0]  diff;
		logic [PROD_W-1:0] product;
		logic              bad;
	} mat_result_t;

	class matrix_board;
		logic signed [ELEM_W-1:0] mat_a [DIM][DIM];
		logic signed [ELEM_W-1:0] mat_b [DIM][DIM];
		bit                       a_set [DIM][DIM];
		bit                       b_set [DIM][DIM];
		logic [SIZE_W-1:0]        size_reg;
		mat_result_t              results[$];
		int                       errors;

		function new();
			size_reg = SIZE_RESET;
			errors = 0;
		endfunction

		function int active_n();
			return (size_reg > DIM) ? DIM : int'(size_reg);
		endfunction

		// Find an entry that a query at (row, col) would read before it was written.
		function bit first_unset(int row, int col, output bit in_b, output int er, output int ec);
			int n;
			n = active_n();
			for (int k = 0; k < n; k++) begin
				if (!a_set[row][k]) begin
					in_b = 0; er = row; ec = k;
					return 1;
				end
				if (!b_set[k][col]) begin
					in_b = 1; er = k; ec = col;
					return 1;
				end
			end
			return 0;
		endfunction

		function void take_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
				logic [IDX_W-1:0] col, logic [ELEM_W-1:0] value);
			int n;
			bit in_range;
			longint acc;
			mat_result_t want;
			logic signed [ELEM_W-1:0] a, b;
			n = active_n();
			in_range = (row < n) && (col < n);
			case (op)
				OP_WRITE_A: if (in_range) begin
					mat_a[row][col] = value;
					a_set[row][col] = 1;
				end
				OP_WRITE_B: if (in_range) begin
					mat_b[row][col] = value;
					b_set[row][col] = 1;
				end
				OP_QUERY: begin
					want = '{default: '0};
					if (!in_range) begin
						want.bad = 1'b1;
					end else begin
						a = mat_a[row][col];
						b = mat_b[row][col];
						acc = 0;
						for (int k = 0; k < n; k++)
							acc += longint'(mat_a[row][k]) * longint'(mat_b[k][col]);
						want.sum = {a[ELEM_W-1], a} + {b[ELEM_W-1], b};
						want.diff = {a[ELEM_W-1], a} - {b[ELEM_W-1], b};
						want.product = acc[PROD_W-1:0];
					end
					results.push_back(want);
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [71:0] data, logic [0:0] user);
			mat_result_t want;
			if (results.size() == 0) begin
				$error("result with no query pending: data %h bad_index %0d", data, user[0]);
				errors++;
				return;
			end
			want = results.pop_front();
			if (data[16:0] !== want.sum) begin
				$error("sum expected %0d got %0d", $signed(want.sum), $signed(data[16:0]));
				errors++;
			end
			if (data[33:17] !== want.diff) begin
				$error("difference expected %0d got %0d", $signed(want.diff),
					$signed(data[33:17]));
				errors++;
			end
			if (data[69:34] !== want.product) begin
				$error("product expected %0d got %0d", $signed(want.product),
					$signed(data[69:34]));
				errors++;
			end
			if (user[0] !== want.bad) begin
				$error("bad_index expected %0d got %0d", want.bad, user[0]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [4:0]  cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // row[3:0], col[7:4], value[23:8]
	logic [1:0]  s_axis_tuser = '0;   // operation[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;        // sum[16:0], difference[33:17], product[69:34], zero pad
	logic [0:0]  m_axis_tuser;        // bad_index[0]

	matrix_board sb;
	bit          steady = 0;
	int          stall_cycles = 0;

	square_matrix_add_sub_mul_core #(.MAX_N(DIM)) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n)
			m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 35);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_req(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
			logic [IDX_W-1:0] col, logic [ELEM_W-1:0] value);
		while (!steady && $urandom_range(99) < 35) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {value, col, row};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		sb.take_request(op, row, col, value);
	endtask

	// Hold requests until every pending result has been taken.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.results.size() != 0) @(posedge clk);
	endtask

	task automatic write_size(logic [SIZE_W-1:0] size);
		drain_results();
		repeat (SETTLE) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= size;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.size_reg = size;
	endtask

	function automatic logic [ELEM_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	task automatic pick_item(output logic [OP_W-1:0] op, output logic [IDX_W-1:0] row,
			output logic [IDX_W-1:0] col, output logic [ELEM_W-1:0] value);
		int n, roll, er, ec;
		bit in_b;
		n = sb.active_n();
		roll = $urandom_range(99);
		value = pick_value();
		op = OP_QUERY;
		row = IDX_W'($urandom_range(15));
		col = IDX_W'($urandom_range(15));
		if (roll < 4) begin
			op = OP_UNUSED;
		end else if (roll < 20 && n < DIM) begin
			op = (roll < 12) ? OP_QUERY : (roll[0] ? OP_WRITE_B : OP_WRITE_A);
			if ($urandom_range(1))
				row = IDX_W'($urandom_range(15, n));
			else
				col = IDX_W'($urandom_range(15, n));
		end else if (n > 0) begin
			row = IDX_W'($urandom_range(n - 1));
			col = IDX_W'($urandom_range(n - 1));
			if (roll < 55) begin
				op = roll[0] ? OP_WRITE_B : OP_WRITE_A;
			end else if (sb.first_unset(row, col, in_b, er, ec)) begin
				// fill the missing entry first; the query comes later
				op = in_b ? OP_WRITE_B : OP_WRITE_A;
				row = IDX_W'(er);
				col = IDX_W'(ec);
			end
		end
	endtask

	task automatic run_random(int quota);
		int done;
		logic [OP_W-1:0]   op;
		logic [IDX_W-1:0]  row, col;
		logic [ELEM_W-1:0] value;
		done = 0;
		while (done < quota) begin
			if ($urandom_range(99) == 0)
				drain_results();
			pick_item(op, row, col, value);
			done++;
			send_req(op, row, col, value);
		end
	endtask

	task automatic run_directed();
		write_size(5'd1);
		send_req(OP_WRITE_A, 0, 0, 16'h8000);
		send_req(OP_WRITE_B, 0, 0, 16'h8000);
		send_req(OP_QUERY, 0, 0, 16'h0000);
		send_req(OP_WRITE_B, 0, 0, 16'h7FFF);
		send_req(OP_QUERY, 0, 0, 16'hFFFF);
		send_req(OP_WRITE_A, 0, 0, 16'h7FFF);
		send_req(OP_QUERY, 0, 0, 16'h0000);
		send_req(OP_WRITE_A, 15, 15, 16'h5555);
		send_req(OP_UNUSED, 15, 15, 16'hFFFF);
		send_req(OP_QUERY, 15, 15, 16'h0000);
		send_req(OP_QUERY, 0, 15, 16'h0000);
		send_req(OP_QUERY, 15, 0, 16'h0000);
		// size zero: writes drop, every query is out of range
		write_size(5'd0);
		send_req(OP_WRITE_A, 0, 0, 16'h1234);
		send_req(OP_QUERY, 0, 0, 16'h0000);
		write_size(5'd2);
		send_req(OP_WRITE_A, 1, 0, 16'h8000);
		send_req(OP_WRITE_A, 1, 1, 16'h8000);
		send_req(OP_WRITE_B, 0, 1, 16'h8000);
		send_req(OP_WRITE_B, 1, 1, 16'h8000);
		send_req(OP_QUERY, 1, 1, 16'h0000);
		send_req(OP_QUERY, 1, 2, 16'h0000);
	endtask

	initial begin
		int sizes [8];
		int size;
		sizes = '{16, 3, 31, 1, 9, 16, 5, 0};
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int p = 0; p < 8; p++) begin
			size = (p == 7) ? $urandom_range(1, 20) : sizes[p];
			write_size(SIZE_W'(size));
			steady = (p == 5);
			run_random(PHASE_ITEMS);
			steady = 0;
		end
		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ square_matrix_add_sub_mul_core.f @@
rtl/smas_pkg.sv
rtl/smas_ram.sv
rtl/smas_mac.sv
rtl/smas_ctrl.sv
rtl/square_matrix_add_sub_mul_core.sv
tb/tb_top.sv
